// ===== sv/kfts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfts_pkg: shared types for the two-state Kalman step
// Sequencer states and register indexes.
// ----------------------------------------------------------------------------
package kfts_pkg;

  typedef enum logic [1:0] {
    REG_TIME_STEP  = 2'd0,
    REG_PROC_SIGMA = 2'd1,
    REG_MEAS_NOISE = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DIV  = 2'd2,
    ST_OUT  = 2'd3
  } state_e;

endpackage

// ===== sv/kalman_filter_two_state_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_filter_two_state_step: constant velocity Kalman filter step
// Predict and update of a (value, rate) estimate with 2x2 covariance.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: measurement_i with in_valid_i / in_stall_o. One item is
//    one measurement; the block stalls the input while it works on an item.
//  - Output channel: out_valid_o / out_stall_i with the new estimate, the
//    covariance and bad_variance_o. The result register holds while the
//    receiver stalls, and the next item is taken meanwhile; that item waits
//    at its end until the held result has been taken.
//  - Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i;
//    write only while idle. Index 3 is ignored.
// Datapath: one shared multiplier (one product per cycle while the sequencer
// runs, 13 products over 15 steps) and a bit-serial divider, run twice for
// the two gains. When the innovation variance is not positive the divides
// are skipped.
// Reset: estimate and covariance clear to zero, registers take their
// default values (dt 0.1 s, sigma 1.0, R 0.124).
// ----------------------------------------------------------------------------
module kalman_filter_two_state_step #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  measurement_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  value_est_o,
  output logic signed [31:0]  rate_est_o,
  output logic signed [31:0]  cov_value_o,
  output logic signed [31:0]  cov_cross_o,
  output logic signed [31:0]  cov_rate_o,
  output logic                bad_variance_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import kfts_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  // compare width wide enough for both W-bit words and 32-bit fields
  localparam int XW = ((W > 32) ? W : 32) + 2;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [F+1:0] ONE_Q = (F+2)'(1) << F;

  // configuration
  logic [15:0] dt_q;
  logic [30:0] sg_q, rn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= 16'((ONE_Q + 5) / 10);
      sg_q <= 31'(ONE_Q);
      rn_q <= 31'((124 * ONE_Q) / 1000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TIME_STEP:  dt_q <= cfg_data_i[15:0];
        REG_PROC_SIGMA: sg_q <= cfg_data_i[30:0];
        REG_MEAS_NOISE: rn_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // clamp a wider value to W bits
  function automatic logic signed [W-1:0] clamp(input logic signed [W+1:0] v);
    if (v > (W+2)'(WMAX)) return WMAX;
    if (v < (W+2)'(WMIN)) return WMIN;
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] clamp_u(input logic [31:0] v);
    if (XW'(v) > XW'(WMAX)) return WMAX;
    return W'(v);
  endfunction

  function automatic logic signed [W-1:0] clamp_in(input logic signed [31:0] v);
    if (XW'(v) > XW'(WMAX)) return WMAX;
    if (XW'(v) < XW'(WMIN)) return WMIN;
    return W'(v);
  endfunction

  function automatic logic signed [31:0] outw(input logic signed [W-1:0] v);
    if (XW'(v) > XW'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (XW'(v) < XW'(32'sh80000000)) return 32'sh80000000;
    return 32'(v);
  endfunction

  // saturating add / subtract
  function automatic logic signed [W-1:0] addw(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    return clamp((W+2)'(a) + (W+2)'(b));
  endfunction
  function automatic logic signed [W-1:0] subw(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    return clamp((W+2)'(a) - (W+2)'(b));
  endfunction

  // state, also the result register
  logic signed [W-1:0] x0_q, x1_q, p00_q, p01_q, p11_q;
  logic                bad_out_q;
  // working registers
  logic signed [W-1:0] dt, sg, rn, z_q;
  logic signed [W-1:0] xp0_q, fp00_q, fp01_q, pp00_q, pp01_q, pp11_q;
  logic signed [W-1:0] g0_q, k0_q, k1_q, y_q, prod_q, x1n_q;
  logic                bad_q;

  state_e st_q, st_d;
  logic [3:0] step_q, step_d;

  logic div_start, div_done, div_sel_q;
  logic signed [W-1:0] div_num, div_q;
  logic signed [W-1:0] s_val;
  logic                s_bad;
  logic accept_in, res_free;

  assign dt = clamp_u({16'd0, dt_q});
  assign sg = clamp_u({1'b0, sg_q});
  assign rn = clamp_u({1'b0, rn_q});

  // shared multiplier operands; the product is used one step later
  logic signed [W-1:0] ma, mb;
  always_comb begin
    ma = dt;
    mb = x1_q;
    case (step_q)
      4'd0: begin ma = dt;   mb = x1_q;   end
      4'd1: begin ma = dt;   mb = p01_q;  end
      4'd2: begin ma = dt;   mb = p11_q;  end
      4'd3: begin ma = dt;   mb = sg;     end
      4'd4: begin ma = dt;   mb = fp01_q; end
      4'd5: begin ma = g0_q; mb = g0_q;   end
      4'd6: begin ma = g0_q; mb = sg;     end
      4'd7: begin ma = sg;   mb = sg;     end
      4'd9: begin ma = k0_q; mb = y_q;    end
      4'd10: begin ma = k1_q; mb = y_q;    end
      4'd11: begin ma = k0_q; mb = pp00_q; end
      4'd12: begin ma = k0_q; mb = pp01_q; end
      4'd13: begin ma = k1_q; mb = pp01_q; end
      default: ;
    endcase
  end

  // signed Q product, magnitude truncated, saturated
  logic              mneg;
  logic [W-1:0]      mua, mub, mlim;
  logic [2*W-1:0]    mfull;
  logic [2*W-F-1:0]  msh;
  logic [W-1:0]      mmag;
  logic signed [W-1:0] mres;
  always_comb begin
    mneg  = ma[W-1] ^ mb[W-1];
    mua   = ma[W-1] ? (~ma + 1'b1) : ma;
    mub   = mb[W-1] ? (~mb + 1'b1) : mb;
    mfull = mua * mub;
    msh   = mfull[2*W-1:F];
    mlim  = mneg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    mmag  = (msh > (2*W-F)'(mlim)) ? mlim : msh[W-1:0];
    mres  = mneg ? W'(~mmag + 1'b1) : mmag;
  end

  // innovation variance S; pp00 holds its predicted value from step 7 to 12
  assign s_val = addw(pp00_q, rn);
  assign s_bad = s_val[W-1] || (s_val == '0);

  // first run divides P00, the second (started from ST_DIV) P01
  assign div_num = (st_q == ST_DIV) ? pp01_q : pp00_q;

  kfts_div #(.W(W), .FRAC(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_val),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  assign res_free    = !out_valid_o || !out_stall_i;
  assign accept_in   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (st_q != ST_IDLE);
  assign cfg_ready_o = (st_q == ST_IDLE);

  // sequencer: steps 0-8 predict, gain divides if S > 0, steps 9-14 update
  always_comb begin
    st_d      = st_q;
    step_d    = step_q;
    div_start = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (accept_in) begin
          st_d   = ST_RUN;
          step_d = '0;
        end
      end
      ST_RUN: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd8 && !s_bad) begin
          st_d      = ST_DIV;
          div_start = 1'b1;
        end
        if (step_q == 4'd14) st_d = ST_OUT;
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_sel_q) st_d = ST_RUN;
          else div_start = 1'b1;
        end
      end
      ST_OUT: if (res_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      step_q      <= '0;
      out_valid_o <= 1'b0;
      x0_q <= '0; x1_q <= '0; p00_q <= '0; p01_q <= '0; p11_q <= '0;
      bad_out_q   <= 1'b0;
      div_sel_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      if (st_q == ST_IDLE && accept_in) div_sel_q <= 1'b0;
      else if (st_q == ST_DIV && div_done) div_sel_q <= 1'b1;
      if (st_q == ST_OUT && res_free) begin
        out_valid_o <= 1'b1;
        x0_q      <= xp0_q;
        x1_q      <= x1n_q;
        p00_q     <= pp00_q;
        p01_q     <= pp01_q;
        p11_q     <= pp11_q;
        bad_out_q <= bad_q;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // datapath; at the end xp0/x1n/pp* hold the updated state
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && accept_in) z_q <= clamp_in(measurement_i);
    if (st_q == ST_RUN) prod_q <= mres;
    if (st_q == ST_DIV && div_done) begin
      if (div_sel_q) k1_q <= div_q;
      else k0_q <= div_q;
    end
    if (st_q == ST_RUN) begin
      case (step_q)
        4'd1: xp0_q  <= addw(x0_q, prod_q);
        4'd2: fp00_q <= addw(p00_q, prod_q);
        4'd3: fp01_q <= addw(p01_q, prod_q);
        4'd4: g0_q   <= prod_q;
        4'd5: pp00_q <= addw(fp00_q, prod_q);
        4'd6: pp00_q <= addw(pp00_q, prod_q);
        4'd7: pp01_q <= addw(fp01_q, prod_q);
        4'd8: begin
          pp11_q <= addw(p11_q, prod_q);
          y_q    <= subw(z_q, xp0_q);
          bad_q  <= s_bad;
          // gain forced to zero, estimate stays at the prediction
          if (s_bad) begin
            k0_q <= '0;
            k1_q <= '0;
          end
        end
        4'd10: xp0_q  <= addw(xp0_q, prod_q);
        4'd11: x1n_q  <= addw(x1_q, prod_q);
        4'd12: pp00_q <= subw(pp00_q, prod_q);
        4'd13: pp01_q <= subw(pp01_q, prod_q);
        4'd14: pp11_q <= subw(pp11_q, prod_q);
        default: ;
      endcase
    end
  end

  assign value_est_o    = outw(x0_q);
  assign rate_est_o     = outw(x1_q);
  assign cov_value_o    = outw(p00_q);
  assign cov_cross_o    = outw(p01_q);
  assign cov_rate_o     = outw(p11_q);
  assign bad_variance_o = bad_out_q;
endmodule

// ===== sv/kfts_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfts_div: fixed point divider
// Restoring divide of (num << FRAC) / den, one bit per cycle, saturated.
// ----------------------------------------------------------------------------
module kfts_div #(
  parameter int W    = 32,
  parameter int FRAC = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] num_i,
  input  logic signed [W-1:0] den_i,
  output logic                done_o,
  output logic signed [W-1:0] quot_o
);
  localparam int NB = W + FRAC;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] dvd_q, dvd_d;
  logic [W:0]    rem_q, rem_d;
  logic [NB-1:0] quo_q, quo_d;
  logic [W-1:0]  den_q;
  logic          neg_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q;
  logic [W:0]    trial;
  logic [W-1:0]  mag;
  logic [NB-1:0] lim;

  assign mag = num_i[W-1] ? (~num_i + 1'b1) : num_i;
  assign lim = neg_q ? {{FRAC{1'b0}}, 1'b1, {(W-1){1'b0}}}
                     : {{(FRAC+1){1'b0}}, {(W-1){1'b1}}};

  always_comb begin
    trial = {rem_q[W-1:0], dvd_q[NB-1]};
    dvd_d = {dvd_q[NB-2:0], 1'b0};
    rem_d = trial;
    quo_d = {quo_q[NB-2:0], 1'b0};
    if (trial >= {1'b0, den_q}) begin
      rem_d    = trial - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
    cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_d;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag, {FRAC{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[W-1];
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // quotient only grows, so the saturation check at the end matches
  logic [NB-1:0] qs;
  assign qs = (quo_q > lim) ? lim : quo_q;
  assign quot_o = neg_q ? W'(~qs + 1'b1) : qs[W-1:0];
endmodule

// ===== bench/kfts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfts_checker: scoreboard for the two-state Kalman step
// Tracks register writes, predicts each filter step and checks every result.
// ----------------------------------------------------------------------------
module kfts_checker (
  input  logic               clk_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] measurement_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] value_est_i,
  input  logic signed [31:0] rate_est_i,
  input  logic signed [31:0] cov_value_i,
  input  logic signed [31:0] cov_cross_i,
  input  logic signed [31:0] cov_rate_i,
  input  logic               bad_variance_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 pending_o,
  output int                 fail_count_o,
  output int                 checked_o,
  output int                 bad_seen_o
);
  import kfts_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] rate;
    logic signed [31:0] cv;
    logic signed [31:0] cc;
    logic signed [31:0] cr;
    logic               bad;
  } step_result_t;

  step_result_t est_q[$];

  // filter state and registers, in 32-bit signed range
  longint x_val, x_rate, p_val, p_cross, p_rate;
  longint dt_reg, sigma_reg, noise_reg;

  initial begin
    x_val = 0; x_rate = 0; p_val = 0; p_cross = 0; p_rate = 0;
    dt_reg = 6554; sigma_reg = 65536; noise_reg = 8126;
    fail_count_o = 0; checked_o = 0; bad_seen_o = 0;
  end

  assign pending_o = est_q.size();

  function automatic longint sat(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return longint'(v);
  endfunction

  // product with magnitude truncated toward zero
  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] pa, pb, p, m;
    pa = a; pb = b;
    p = pa * pb;
    m = (p < 0) ? -p : p;
    m = m >>> 16;
    return sat((p < 0) ? -m : m);
  endfunction

  function automatic longint fx_div(longint num, longint den);
    logic signed [127:0] n, d;
    n = num; d = den;
    n = n <<< 16;
    return sat(n / d);
  endfunction

  function automatic step_result_t kalman_step(longint z);
    step_result_t r;
    longint xp0, fp00, fp01, pp00, pp01, pp11, g0, s, k0, k1, y;
    xp0  = sat(x_val + fx_mul(dt_reg, x_rate));
    fp00 = sat(p_val + fx_mul(dt_reg, p_cross));
    fp01 = sat(p_cross + fx_mul(dt_reg, p_rate));
    pp00 = sat(fp00 + fx_mul(dt_reg, fp01));
    g0   = fx_mul(dt_reg, sigma_reg);
    pp00 = sat(pp00 + fx_mul(g0, g0));
    pp01 = sat(fp01 + fx_mul(g0, sigma_reg));
    pp11 = sat(p_rate + fx_mul(sigma_reg, sigma_reg));
    s = sat(pp00 + noise_reg);
    r.bad = (s <= 0);
    if (r.bad) begin
      k0 = 0; k1 = 0;
    end else begin
      k0 = fx_div(pp00, s);
      k1 = fx_div(pp01, s);
    end
    y = sat(z - xp0);
    x_val   = sat(xp0 + fx_mul(k0, y));
    x_rate  = sat(x_rate + fx_mul(k1, y));
    p_val   = sat(pp00 - fx_mul(k0, pp00));
    p_cross = sat(pp01 - fx_mul(k0, pp01));
    p_rate  = sat(pp11 - fx_mul(k1, pp01));
    r.value = x_val[31:0]; r.rate = x_rate[31:0];
    r.cv = p_val[31:0]; r.cc = p_cross[31:0]; r.cr = p_rate[31:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    step_result_t want, got;
    if (cfg_valid_i && cfg_ready_i) begin
      case (cfg_index_i)
        REG_TIME_STEP:  dt_reg    = longint'(cfg_data_i[15:0]);
        REG_PROC_SIGMA: sigma_reg = longint'(cfg_data_i[30:0]);
        REG_MEAS_NOISE: noise_reg = longint'(cfg_data_i[30:0]);
        default: ;
      endcase
    end
    if (in_valid_i && !in_stall_i)
      est_q.push_back(kalman_step(longint'(measurement_i)));
    if (out_valid_i && !out_stall_i) begin
      got = '{value_est_i, rate_est_i, cov_value_i, cov_cross_i, cov_rate_i,
              bad_variance_i};
      if (est_q.size() == 0) begin
        fail_count_o++;
        if (fail_count_o <= 10) $display("unexpected result %h", got);
      end else begin
        want = est_q.pop_front();
        checked_o++;
        if (want.bad) bad_seen_o++;
        if (got !== want) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("mismatch (exp/act): val %0d/%0d rate %0d/%0d p00 %0d/%0d",
                     want.value, got.value, want.rate, got.rate, want.cv, got.cv);
            $display("  p01 %0d/%0d p11 %0d/%0d bad %0b/%0b",
                     want.cc, got.cc, want.cr, got.cr, want.bad, got.bad);
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the two-state Kalman step
// Drives measurements and register settings with random gaps and stalls;
// the checker predicts each step and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import kfts_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] meas;
  logic signed [31:0] value_est, rate_est, cov_value, cov_cross, cov_rate;
  logic bad_var;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  int pending, fails, checked, bad_seen, cycles, sent;
  bit quiet;   // when set, neither side idles

  kalman_filter_two_state_step uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .measurement_i(meas),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .value_est_o(value_est), .rate_est_o(rate_est), .cov_value_o(cov_value),
    .cov_cross_o(cov_cross), .cov_rate_o(cov_rate), .bad_variance_o(bad_var),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  kfts_checker chk (
    .clk_i(clk), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .measurement_i(meas), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .value_est_i(value_est), .rate_est_i(rate_est), .cov_value_i(cov_value),
    .cov_cross_i(cov_cross), .cov_rate_i(cov_rate), .bad_variance_i(bad_var),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .pending_o(pending), .fail_count_o(fails),
    .checked_o(checked), .bad_seen_o(bad_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("kalman_filter_two_state_step regression: fail");
      $finish;
    end
  end

  // receiver side: random stall, none during quiet stretches
  always @(posedge clk)
    out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 10);

  // one measurement item; valid stays high until taken
  task automatic send_meas(input logic [31:0] z);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    meas <= z;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent++;
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  // block must be idle: all results back, plus the step latency
  task automatic wait_idle();
    stop_input();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] dt, input logic [31:0] sg,
                          input logic [31:0] rn);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_PROC_SIGMA, sg);
    write_reg(REG_MEAS_NOISE, rn);
  endtask

  // random measurement: mostly moderate, sometimes any 32-bit word
  function automatic logic [31:0] rand_meas();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; meas = '0; out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    cycles = 0; sent = 0; quiet = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, extreme measurements
    send_meas(32'h0000_0000);
    send_meas(32'h7FFF_FFFF);
    send_meas(32'h8000_0000);
    send_meas(32'hFFFF_FFFF);
    send_meas(32'h0001_0000);
    send_meas(32'hFFFF_0000);
    wait_idle();

    // zero noise: variance collapses after the first step, gain forced off
    set_regs(32'd0, 32'd0, 32'd0);
    send_meas(32'h0001_0000);
    send_meas(32'h8000_0000);
    wait_idle();

    // largest settings: saturation through predict and update
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_meas(32'h7FFF_FFFF);
    send_meas(32'h8000_0000);
    send_meas(32'h0000_0000);
    wait_idle();

    // out of range index is ignored; sigma max with small R
    write_reg(2'd3, 32'h0000_0001);
    set_regs(32'd65535, 32'h7FFF_FFFF, 32'd1);
    send_meas(32'h1234_5678);
    send_meas(32'hEDCB_A988);
    wait_idle();
    set_regs(32'd6554, 32'd65536, 32'd0);
    send_meas(32'h0000_0001);
    send_meas(32'h7FFF_FFFF);
    send_meas(32'h8000_0001);
    wait_idle();

    // random phases with fresh settings between them
    for (int ph = 0; ph < 10; ph++) begin
      if ($urandom_range(0, 3) == 0)
        set_regs($urandom, $urandom, $urandom);
      else
        set_regs($urandom_range(0, 20000), $urandom_range(0, 32'h0004_0000),
                 $urandom_range(0, 32'h0004_0000));
      if ($urandom_range(0, 7) == 0) write_reg(2'd3, $urandom);
      quiet = (ph == 4);
      for (int i = 0; i < 50; i++) send_meas(rand_meas());
      quiet = 1'b0;
      wait_idle();
    end

    $display("sent %0d measurements, checked %0d steps (%0d with bad variance)",
             sent, checked, bad_seen);
    $display("register settings covered reset, zero, maximum and random values");
    if (fails == 0 && pending == 0)
      $display("kalman_filter_two_state_step regression: pass");
    else
      $display("kalman_filter_two_state_step regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kfts_pkg.sv
sv/kfts_div.sv
sv/kalman_filter_two_state_step.sv
bench/kfts_checker.sv
bench/testbench.sv
